// File: src/ldc_pkg.sv
package ldc_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY
    } ldc_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the incoming token
        logic rd_first;   // read the first copy byte at wp - distance
        logic rd_next;    // read the next copy byte at wp + 1 - distance
        logic emit_lit;   // emit and store the literal byte
        logic emit_copy;  // emit and store the byte read from history
        logic emit_err;   // emit an error word
    } ldc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_lit;     // held token is a literal
        logic len_zero;   // held copy length is zero
        logic dist_bad;   // distance zero or beyond the written history
        logic rem_one;    // one copy byte left
        logic out_free;   // output register can take a word this cycle
    } ldc_sts_t;

endpackage

// File: src/ldc_ram.sv
module ldc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ldc_ctrl.sv
module ldc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ldc_pkg::ldc_sts_t sts,
    output ldc_pkg::ldc_cmd_t cmd
);

    ldc_pkg::ldc_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ldc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ldc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ldc_pkg::ST_DECODE;
                end
            end
            ldc_pkg::ST_DECODE: begin
                if (sts.is_lit || sts.dist_bad) begin
                    if (sts.out_free || (!sts.is_lit && sts.len_zero)) begin
                        state_next = ldc_pkg::ST_IDLE;
                    end
                end else if (sts.len_zero) begin
                    state_next = ldc_pkg::ST_IDLE;
                end else begin
                    state_next = ldc_pkg::ST_COPY;
                end
            end
            ldc_pkg::ST_COPY: begin
                if (sts.out_free && sts.rem_one) begin
                    state_next = ldc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ldc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ldc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ldc_pkg::ST_DECODE: begin
                cmd.emit_lit = sts.is_lit && sts.out_free;
                cmd.emit_err = !sts.is_lit && !sts.len_zero && sts.dist_bad
                               && sts.out_free;
                cmd.rd_first = !sts.is_lit && !sts.len_zero && !sts.dist_bad;
            end
            ldc_pkg::ST_COPY: begin
                cmd.emit_copy = sts.out_free;
                cmd.rd_next   = sts.out_free && !sts.rem_one;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/ldc_dp.sv
module ldc_dp #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 4,
    parameter int IN_DW       = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IN_DW-1:0]  s_tdata,
    input  logic              s_tuser,
    input  ldc_pkg::ldc_cmd_t cmd,
    output ldc_pkg::ldc_sts_t sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    localparam int W = WINDOW_BITS;
    localparam int L = LENGTH_BITS;
    localparam logic [W:0] BW_MAX = {1'b1, {W{1'b0}}};

    // Held token
    logic         lit_reg;
    logic [7:0]   byte_reg;
    logic [W-1:0] dist_reg;
    logic [L-1:0] rem_reg;

    // Window bookkeeping
    logic [W-1:0] wp_reg;
    logic [W:0]   bw_reg;

    // Read bypass for a copy one byte back
    logic         fwd_reg;
    logic [7:0]   fwd_data_reg;

    // Output register
    logic         m_valid_reg;
    logic [7:0]   m_data_reg;
    logic         m_last_reg;
    logic         m_err_reg;

    logic         we;
    logic [7:0]   wdata;
    logic         re;
    logic [W-1:0] rd_base;
    logic [W-1:0] raddr;
    logic [7:0]   ram_rdata;
    logic [7:0]   copy_byte;
    logic         out_free;

    ldc_ram #(
        .DATA_W (8),
        .DEPTH  (1 << W)
    ) u_hist (
        .clk   (aclk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Select history enables, write data and read address, and the copy byte
    assign out_free  = !m_valid_reg || m_tready;
    assign copy_byte = fwd_reg ? fwd_data_reg : ram_rdata;
    assign we        = cmd.emit_lit || cmd.emit_copy;
    assign wdata     = cmd.emit_lit ? byte_reg : copy_byte;
    assign re        = cmd.rd_first || cmd.rd_next;
    assign rd_base   = cmd.rd_next ? wp_reg + W'(1) : wp_reg;
    assign raddr     = rd_base - dist_reg;

    // Report status
    always_comb begin
        sts.is_lit   = lit_reg;
        sts.len_zero = (rem_reg == '0);
        sts.dist_bad = (dist_reg == '0) || ({1'b0, dist_reg} > bw_reg);
        sts.rem_one  = (rem_reg == L'(1));
        sts.out_free = out_free;
    end

    // Capture token, count down copy bytes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lit_reg  <= s_tuser;
            byte_reg <= s_tdata[7:0];
            dist_reg <= s_tdata[8 +: W];
            rem_reg  <= s_tdata[8 + W +: L];
        end else if (cmd.emit_copy) begin
            rem_reg  <= rem_reg - L'(1);
        end
    end

    // Hold the byte being written when the read hits the same slot
    always_ff @(posedge aclk) begin
        if (re) begin
            fwd_reg      <= we && (raddr == wp_reg);
            fwd_data_reg <= wdata;
        end
    end

    // Advance write pointer and saturating fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            bw_reg <= '0;
        end else if (we) begin
            wp_reg <= wp_reg + W'(1);
            if (bw_reg != BW_MAX) begin
                bw_reg <= bw_reg + (W+1)'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_lit || cmd.emit_copy || cmd.emit_err) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_lit || cmd.emit_copy || cmd.emit_err) begin
            m_data_reg <= cmd.emit_err ? 8'h00 : wdata;
            m_last_reg <= cmd.emit_copy ? (rem_reg == L'(1)) : 1'b1;
            m_err_reg  <= cmd.emit_err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

endmodule

// File: src/lzss_token_decoder.sv
// LZSS token decoder: takes one unpacked token per word and streams out the
// decompressed bytes, one byte per output word, with tlast on the final byte
// of each token and tuser set on an error word. A token is taken in the idle
// state and decoded in the next cycle; a literal or an error word is written
// to the output register in the decode state once that register is free, and
// a zero-length copy emits nothing. After the first read of the history RAM,
// a back-reference emits one byte per cycle while the output register is
// free, paced by the RAM's single registered read port, with the byte just
// written bypassed when the copy reaches one byte back. Output back-pressure
// holds the decoder while a word waits in the output register with m_tready
// low. The history RAM is not cleared; the distance check against the fill
// count keeps every read within written bytes.
module lzss_token_decoder #(
    parameter int WINDOW_BITS = 12,
    parameter int LENGTH_BITS = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata from bit 0: literal_byte[7:0], distance[WINDOW_BITS-1:0],
    // copy_length[LENGTH_BITS-1:0], zero fill to whole bytes
    input  logic [((8 + WINDOW_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: is_literal
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: out_byte[7:0]
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    // m_tuser: error
    output logic                   m_tuser
);

    localparam int IN_DW = ((8 + WINDOW_BITS + LENGTH_BITS + 7) / 8) * 8;

    ldc_pkg::ldc_cmd_t cmd;
    ldc_pkg::ldc_sts_t sts;

    ldc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ldc_dp #(
        .WINDOW_BITS (WINDOW_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .IN_DW       (IN_DW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An error word is always the zero byte closing its token
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("error word without tlast or with nonzero data");

    // One token at a time: no new word straight after an accept
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a token is in progress");

    // At most one emit per cycle, and only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_lit || cmd.emit_copy || cmd.emit_err) |->
            sts.out_free && $onehot({cmd.emit_lit, cmd.emit_copy, cmd.emit_err}))
        else $error("emit into a busy output register or multiple emits");

endmodule
